### rtl/wrmh_pkg.sv
`default_nettype none
package wrmh_pkg;

	// Heap depth and derived widths
	localparam int CAPACITY = 64;
	localparam int ADR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CH_W     = ADR_W + 2;

	// Fixed field widths
	localparam int CFG_W     = 7;
	localparam int OP_W      = 2;
	localparam int KEY_W     = 64;
	localparam int TAG_W     = 32;
	localparam int KIND_W    = 8;
	localparam int ST_W      = 3;
	localparam int CNT_OUT_W = 7;

	localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

	// Operation codes
	localparam logic [OP_W-1:0] OP_OFFER  = 2'd0;
	localparam logic [OP_W-1:0] OP_FORCE  = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
	localparam logic [OP_W-1:0] OP_POP    = 2'd3;

	// Status codes
	localparam logic [ST_W-1:0] ST_ADDED     = 3'd0;
	localparam logic [ST_W-1:0] ST_DUP       = 3'd1;
	localparam logic [ST_W-1:0] ST_BELOW     = 3'd2;
	localparam logic [ST_W-1:0] ST_REMOVED   = 3'd3;
	localparam logic [ST_W-1:0] ST_FULL      = 3'd4;
	localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd5;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [TAG_W-1:0]  tag;
		logic [KIND_W-1:0] kind;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [OP_W-1:0] op;
		entry_t          ent;
	} req_t;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic             ev_valid;
		entry_t           ev;
		logic [CNT_W-1:0] count;
		logic [KEY_W-1:0] min_key;
		logic [TAG_W-1:0] min_tag;
	} rsp_t;

	// Clamp the capacity register to 1..CAPACITY
	function automatic logic [CNT_W-1:0] cap_clamp(input logic [CFG_W-1:0] v);
		logic [CNT_W-1:0] c;
		if (v == '0) begin
			c = CNT_W'(1);
		end else if (int'(v) > CAPACITY) begin
			c = CNT_W'(CAPACITY);
		end else begin
			c = CNT_W'(v);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

### rtl/wrmh_ram.sv
`default_nettype none
module wrmh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [$clog2(DEPTH)-1:0]         waddr,
	input  wire logic [WIDTH-1:0]                 wdata,
	input  wire logic                             re,
	input  wire logic [$clog2(DEPTH)-1:0]         raddr,
	output logic      [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

### rtl/wrmh_seq.sv
`default_nettype none
module wrmh_seq (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire wrmh_pkg::req_t             req,
	input  wire logic [wrmh_pkg::CNT_W-1:0] cap,
	output logic                            idle,
	output logic                            rsp_valid,
	input  wire logic                       rsp_ready,
	output wrmh_pkg::rsp_t                  rsp
);
	import wrmh_pkg::*;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_START    = 4'd1;
	localparam logic [3:0] S_SCAN     = 4'd2;
	localparam logic [3:0] S_DECIDE   = 4'd3;
	localparam logic [3:0] S_RM_START = 4'd4;
	localparam logic [3:0] S_RM_LAST  = 4'd5;
	localparam logic [3:0] S_DN_L     = 4'd6;
	localparam logic [3:0] S_DN_R     = 4'd7;
	localparam logic [3:0] S_DN_CMP   = 4'd8;
	localparam logic [3:0] S_DN_END   = 4'd9;
	localparam logic [3:0] S_UP       = 4'd10;
	localparam logic [3:0] S_UP_CMP   = 4'd11;
	localparam logic [3:0] S_INS      = 4'd12;
	localparam logic [3:0] S_DONE     = 4'd13;

	logic [3:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic             pend_s1;

	logic [OP_W-1:0]  op_q;
	entry_t           in_q;
	logic [CNT_W-1:0] cap_q;
	entry_t           root_q;
	entry_t           e_q;
	entry_t           left_q;
	logic [ADR_W-1:0] cur_q;
	logic [ADR_W-1:0] pos_q;
	logic [ADR_W-1:0] pend_pos_s1;
	logic [CNT_W-1:0] idx_q;
	logic             found_q;
	logic             strict_q;
	logic             evins_q;
	logic             r_ok_q;
	logic [ST_W-1:0]  status_q;
	logic             ev_valid_q;
	entry_t           ev_q;

	logic             mem_we;
	logic [ADR_W-1:0] mem_waddr;
	entry_t           mem_wdata;
	logic             mem_re;
	logic [ADR_W-1:0] mem_raddr;
	entry_t           rdata;

	logic [CH_W-1:0]  l_w;
	logic [CH_W-1:0]  r_w;
	logic             l_in;
	logic             r_in;
	logic [ADR_W-1:0] l_a;
	logic [ADR_W-1:0] r_a;
	logic [ADR_W-1:0] pm1;
	logic [ADR_W-1:0] parent_a;
	logic [CNT_W-1:0] n_cnt;
	logic             rm_last;
	logic             hit;
	logic             scan_more;
	logic             pick_l;
	logic [KEY_W-1:0] best_key;
	logic             pick_r;
	logic             s_move;
	logic [ADR_W-1:0] s_idx;
	entry_t           child;
	logic             go_up;
	logic             full;
	logic             root_lt;
	logic [3:0]       after_st;

	wrmh_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(rdata)
	);

	// Heap index arithmetic and compares
	always_comb begin
		l_w       = {1'b0, cur_q, 1'b1};
		r_w       = l_w + CH_W'(1);
		l_in      = l_w < CH_W'(count_q);
		r_in      = r_w < CH_W'(count_q);
		l_a       = l_w[ADR_W-1:0];
		r_a       = r_w[ADR_W-1:0];
		pm1       = cur_q - ADR_W'(1);
		parent_a  = pm1 >> 1;
		n_cnt     = count_q - CNT_W'(1);
		rm_last   = CNT_W'(pos_q) == n_cnt;
		hit       = pend_s1 && (rdata.tag == in_q.tag);
		scan_more = idx_q < count_q;
		pick_l    = left_q.key < e_q.key;
		best_key  = pick_l ? left_q.key : e_q.key;
		pick_r    = r_ok_q && (rdata.key < best_key);
		s_move    = pick_l || pick_r;
		s_idx     = pick_r ? r_a : l_a;
		child     = pick_r ? rdata : left_q;
		go_up     = strict_q ? (e_q.key < rdata.key) : !(rdata.key < e_q.key);
		full      = !(count_q < cap_q);
		root_lt   = root_q.key < in_q.key;
		after_st  = evins_q ? S_INS : S_DONE;
	end

	// Memory port control
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = '0;
		mem_we    = 1'b0;
		mem_waddr = cur_q;
		mem_wdata = e_q;
		case (state_q)
			S_SCAN: begin
				if (!hit && scan_more) begin
					mem_re    = 1'b1;
					mem_raddr = idx_q[ADR_W-1:0];
				end
			end
			S_RM_START: begin
				if (!rm_last) begin
					mem_re    = 1'b1;
					mem_raddr = n_cnt[ADR_W-1:0];
				end
			end
			S_DN_L: begin
				if (l_in) begin
					mem_re    = 1'b1;
					mem_raddr = l_a;
				end
			end
			S_DN_R: begin
				if (r_in) begin
					mem_re    = 1'b1;
					mem_raddr = r_a;
				end
			end
			S_DN_CMP: begin
				if (s_move) begin
					mem_we    = 1'b1;
					mem_wdata = child;
				end
			end
			S_DN_END: begin
				mem_we = cur_q != pos_q;
			end
			S_UP: begin
				if (cur_q == '0) begin
					mem_we = 1'b1;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = parent_a;
				end
			end
			S_UP_CMP: begin
				mem_we    = 1'b1;
				mem_wdata = go_up ? rdata : e_q;
			end
			default: begin
			end
		endcase
	end

	// Sequencer state, entry count and scan pending flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			pend_s1 <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					pend_s1 <= 1'b0;
					if (start) begin
						state_q <= S_START;
					end
				end
				S_START: begin
					case (op_q)
						OP_OFFER: begin
							if (full && (count_q == '0 || !root_lt)) begin
								state_q <= S_DONE;
							end else begin
								state_q <= S_SCAN;
							end
						end
						OP_FORCE, OP_REMOVE: state_q <= S_SCAN;
						default: begin
							state_q <= (count_q == '0) ? S_DONE : S_RM_START;
						end
					endcase
				end
				S_SCAN: begin
					if (hit || !scan_more) begin
						pend_s1 <= 1'b0;
						state_q <= S_DECIDE;
					end else begin
						pend_s1 <= 1'b1;
					end
				end
				S_DECIDE: begin
					case (op_q)
						OP_OFFER: begin
							if (found_q) begin
								state_q <= S_DONE;
							end else if (!full) begin
								state_q <= S_INS;
							end else begin
								state_q <= S_RM_START;
							end
						end
						OP_FORCE: begin
							state_q <= (found_q || full) ? S_DONE : S_INS;
						end
						OP_REMOVE: begin
							state_q <= found_q ? S_RM_START : S_DONE;
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_RM_START: begin
					count_q <= n_cnt;
					state_q <= rm_last ? after_st : S_RM_LAST;
				end
				S_RM_LAST: state_q <= S_DN_L;
				S_DN_L:    state_q <= l_in ? S_DN_R : S_DN_END;
				S_DN_R:    state_q <= S_DN_CMP;
				S_DN_CMP:  state_q <= s_move ? S_DN_L : S_DN_END;
				S_DN_END:  state_q <= (cur_q == pos_q) ? S_UP : after_st;
				S_UP:      state_q <= (cur_q == '0) ? after_st : S_UP_CMP;
				S_UP_CMP:  state_q <= go_up ? S_UP : after_st;
				S_INS: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= S_UP;
				end
				S_DONE: begin
					if (rsp_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Operation datapath
	always_ff @(posedge clk) begin
		if (mem_we && mem_waddr == '0) begin
			root_q <= mem_wdata;
		end
		case (state_q)
			S_IDLE: begin
				if (start) begin
					in_q       <= req.ent;
					op_q       <= req.op;
					cap_q      <= cap;
					status_q   <= ST_ADDED;
					ev_valid_q <= 1'b0;
					ev_q       <= '0;
					idx_q      <= '0;
					found_q    <= 1'b0;
					evins_q    <= 1'b0;
					strict_q   <= 1'b0;
					r_ok_q     <= 1'b0;
				end
			end
			S_START: begin
				case (op_q)
					OP_OFFER: begin
						if (full && (count_q == '0 || !root_lt)) begin
							status_q <= ST_BELOW;
						end
					end
					OP_POP: begin
						if (count_q == '0) begin
							status_q <= ST_FULL;
						end else begin
							status_q   <= ST_REMOVED;
							ev_valid_q <= 1'b1;
							ev_q       <= root_q;
							pos_q      <= '0;
						end
					end
					default: begin
					end
				endcase
			end
			S_SCAN: begin
				if (hit) begin
					found_q <= 1'b1;
					pos_q   <= pend_pos_s1;
					left_q  <= rdata;
				end else if (scan_more) begin
					pend_pos_s1 <= idx_q[ADR_W-1:0];
					idx_q       <= idx_q + CNT_W'(1);
				end
			end
			S_DECIDE: begin
				case (op_q)
					OP_OFFER: begin
						if (found_q) begin
							status_q <= ST_DUP;
						end else if (full) begin
							ev_valid_q <= 1'b1;
							ev_q       <= root_q;
							pos_q      <= '0;
							evins_q    <= 1'b1;
						end
					end
					OP_FORCE: begin
						if (found_q) begin
							status_q <= ST_DUP;
						end else if (full) begin
							status_q <= ST_FULL;
						end
					end
					OP_REMOVE: begin
						if (!found_q) begin
							status_q <= ST_NOT_FOUND;
						end else begin
							status_q   <= ST_REMOVED;
							ev_valid_q <= 1'b1;
							ev_q       <= left_q;
						end
					end
					default: begin
					end
				endcase
			end
			S_RM_LAST: begin
				e_q   <= rdata;
				cur_q <= pos_q;
			end
			S_DN_R: begin
				left_q <= rdata;
				r_ok_q <= r_in;
			end
			S_DN_CMP: begin
				if (s_move) begin
					cur_q <= s_idx;
				end
			end
			S_DN_END: begin
				if (cur_q == pos_q) begin
					strict_q <= 1'b1;
				end
			end
			S_UP_CMP: begin
				if (go_up) begin
					cur_q <= parent_a;
				end
			end
			S_INS: begin
				e_q      <= in_q;
				cur_q    <= count_q[ADR_W-1:0];
				strict_q <= 1'b0;
				evins_q  <= 1'b0;
			end
			default: begin
			end
		endcase
	end

	// Result toward the output register
	always_comb begin
		rsp.status   = status_q;
		rsp.ev_valid = ev_valid_q;
		rsp.ev       = ev_q;
		rsp.count    = count_q;
		rsp.min_key  = (count_q != '0) ? root_q.key : '0;
		rsp.min_tag  = (count_q != '0) ? root_q.tag : '0;
	end

	assign idle      = state_q == S_IDLE;
	assign rsp_valid = state_q == S_DONE;

endmodule
`default_nettype wire

### rtl/weighted_reservoir_min_heap.sv
// Channel   Handshake             Payload
// in        in_valid / in_ready   opcode, entry_key, entry_tag, entry_kind
// out       out_valid / out_ready status, evicted_*, entry_count, min_key, min_tag
// cfg       cfg_wr_en             cfg_wr_data (reservoir capacity)
//
// One request at a time; the heap RAM does one read and one write per cycle.
// A request may first scan the stored tags (a pop, or an offer refused as below, skips
// the scan), then sifts entries down or up the heap level by level.
// Reset clears the entry count and loads 64 into the capacity register; RAM is kept.
// A finished result waits in the output register; the next request is taken meanwhile.
// A result still held there and not taken stalls the sequencer at its last step.
`default_nettype none
module weighted_reservoir_min_heap (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wr_en,
	input  wire logic [wrmh_pkg::CFG_W-1:0]     cfg_wr_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [wrmh_pkg::OP_W-1:0]      opcode,
	input  wire logic [wrmh_pkg::KEY_W-1:0]     entry_key,
	input  wire logic [wrmh_pkg::TAG_W-1:0]     entry_tag,
	input  wire logic [wrmh_pkg::KIND_W-1:0]    entry_kind,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [wrmh_pkg::ST_W-1:0]           status,
	output logic                                evicted_valid,
	output logic [wrmh_pkg::KEY_W-1:0]          evicted_key,
	output logic [wrmh_pkg::TAG_W-1:0]          evicted_tag,
	output logic [wrmh_pkg::KIND_W-1:0]         evicted_kind,
	output logic [wrmh_pkg::CNT_OUT_W-1:0]      entry_count,
	output logic [wrmh_pkg::KEY_W-1:0]          min_key,
	output logic [wrmh_pkg::TAG_W-1:0]          min_tag
);
	import wrmh_pkg::*;

	logic [CFG_W-1:0] cfg_q;
	logic             out_valid_q;
	rsp_t             out_q;
	req_t             req;
	rsp_t             rsp;
	logic             seq_idle;
	logic             rsp_valid;
	logic             rsp_ready;
	logic             start;

	// Capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wr_en) begin
			cfg_q <= cfg_wr_data;
		end
	end

	assign req.op       = opcode;
	assign req.ent.key  = entry_key;
	assign req.ent.tag  = entry_tag;
	assign req.ent.kind = entry_kind;
	assign in_ready     = seq_idle;
	assign start        = in_valid && seq_idle;
	assign rsp_ready    = !out_valid_q || out_ready;

	wrmh_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.cap      (cap_clamp(cfg_q)),
		.idle     (seq_idle),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	// Output register: load a finished result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rsp_valid && rsp_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_valid && rsp_ready) begin
			out_q <= rsp;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_q.status;
	assign evicted_valid = out_q.ev_valid;
	assign evicted_key   = out_q.ev.key;
	assign evicted_tag   = out_q.ev.tag;
	assign evicted_kind  = out_q.ev.kind;
	assign entry_count   = CNT_OUT_W'(out_q.count);
	assign min_key       = out_q.min_key;
	assign min_tag       = out_q.min_tag;

endmodule
`default_nettype wire

### test/weighted_reservoir_min_heap_tb.sv
`default_nettype none
module weighted_reservoir_min_heap_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wrmh_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int POOL_SIZE   = 96;

	typedef struct {
		logic [ST_W-1:0]      status;
		logic                 ev_valid;
		logic [KEY_W-1:0]     ev_key;
		logic [TAG_W-1:0]     ev_tag;
		logic [KIND_W-1:0]    ev_kind;
		logic [CNT_OUT_W-1:0] count;
		logic [KEY_W-1:0]     min_key;
		logic [TAG_W-1:0]     min_tag;
	} heap_result_t;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 cfg_wr_en   = 1'b0;
	logic [CFG_W-1:0]     cfg_wr_data = '0;
	logic                 in_valid    = 1'b0;
	logic                 in_ready;
	logic [OP_W-1:0]      opcode      = OP_OFFER;
	logic [KEY_W-1:0]     entry_key   = '0;
	logic [TAG_W-1:0]     entry_tag   = '0;
	logic [KIND_W-1:0]    entry_kind  = '0;
	logic                 out_valid;
	logic                 out_ready   = 1'b0;
	logic [ST_W-1:0]      status;
	logic                 evicted_valid;
	logic [KEY_W-1:0]     evicted_key;
	logic [TAG_W-1:0]     evicted_tag;
	logic [KIND_W-1:0]    evicted_kind;
	logic [CNT_OUT_W-1:0] entry_count;
	logic [KEY_W-1:0]     min_key;
	logic [TAG_W-1:0]     min_tag;

	// Shadow copy of the reservoir
	logic [KEY_W-1:0]  held_key [CAPACITY];
	logic [TAG_W-1:0]  held_tag [CAPACITY];
	logic [KIND_W-1:0] held_kind [CAPACITY];
	int                held_count;
	logic [CFG_W-1:0]  capacity_reg;

	heap_result_t pending_results[$];
	heap_result_t rx_want;
	logic [TAG_W-1:0] tag_pool [POOL_SIZE];
	int mismatches    = 0;
	int tx_burst_left = 0;
	int rx_tick       = 0;
	int rx_mode       = 0;
	int idle_cycles   = 0;

	weighted_reservoir_min_heap DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.entry_key    (entry_key),
		.entry_tag    (entry_tag),
		.entry_kind   (entry_kind),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.evicted_valid(evicted_valid),
		.evicted_key  (evicted_key),
		.evicted_tag  (evicted_tag),
		.evicted_kind (evicted_kind),
		.entry_count  (entry_count),
		.min_key      (min_key),
		.min_tag      (min_tag)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Effective capacity: zero acts as one, oversize acts as full depth
	function automatic int capacity_limit();
		int c;
		c = int'(capacity_reg);
		if (c == 0) c = 1;
		if (c > CAPACITY) c = CAPACITY;
		return c;
	endfunction

	function automatic bit tag_held(input logic [TAG_W-1:0] tag, output int pos);
		int i;
		pos = 0;
		for (i = 0; i < held_count; i++) begin
			if (held_tag[i] == tag) begin
				pos = i;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic void copy_slot(input int dst, input int src);
		held_key[dst]  = held_key[src];
		held_tag[dst]  = held_tag[src];
		held_kind[dst] = held_kind[src];
	endfunction

	// Bubble toward the root; inserts pass equal parents, refills only greater ones
	function automatic void sift_up(input int start, input logic [KEY_W-1:0] key,
			input logic [TAG_W-1:0] tag, input logic [KIND_W-1:0] kind, input bit strict);
		int pos;
		int parent;
		bit go;
		pos = start;
		while (pos > 0) begin
			parent = (pos - 1) / 2;
			go = strict ? (key < held_key[parent]) : !(held_key[parent] < key);
			if (!go) break;
			copy_slot(pos, parent);
			pos = parent;
		end
		held_key[pos]  = key;
		held_tag[pos]  = tag;
		held_kind[pos] = kind;
	endfunction

	function automatic void insert_entry(input logic [KEY_W-1:0] key,
			input logic [TAG_W-1:0] tag, input logic [KIND_W-1:0] kind);
		int pos;
		pos = held_count;
		if (pos >= CAPACITY) return;
		held_count = pos + 1;
		sift_up(pos, key, tag, kind, 1'b0);
	endfunction

	// Refill the hole with the last entry, then sift down or up
	function automatic void remove_slot(input int pos);
		int n;
		int cur;
		int l;
		int r;
		int s;
		logic [KEY_W-1:0]  sk;
		logic [KEY_W-1:0]  last_key;
		logic [TAG_W-1:0]  last_tag;
		logic [KIND_W-1:0] last_kind;
		if (held_count == 0 || pos >= held_count) return;
		n = held_count - 1;
		held_count = n;
		if (pos == n) return;
		last_key  = held_key[n];
		last_tag  = held_tag[n];
		last_kind = held_kind[n];
		cur = pos;
		forever begin
			l = 2 * cur + 1;
			r = 2 * cur + 2;
			s = cur;
			sk = last_key;
			if (l < n && held_key[l] < sk) begin
				s = l;
				sk = held_key[l];
			end
			if (r < n && held_key[r] < sk) s = r;
			if (s == cur) break;
			copy_slot(cur, s);
			cur = s;
		end
		if (cur == pos) begin
			sift_up(pos, last_key, last_tag, last_kind, 1'b1);
		end else begin
			held_key[cur]  = last_key;
			held_tag[cur]  = last_tag;
			held_kind[cur] = last_kind;
		end
	endfunction

	// Apply one request to the shadow heap and return the expected response
	function automatic heap_result_t predict_heap_op(input logic [OP_W-1:0] op,
			input logic [KEY_W-1:0] key, input logic [TAG_W-1:0] tag,
			input logic [KIND_W-1:0] kind);
		heap_result_t res;
		int cap;
		int pos;
		cap = capacity_limit();
		res.status   = ST_ADDED;
		res.ev_valid = 1'b0;
		res.ev_key   = '0;
		res.ev_tag   = '0;
		res.ev_kind  = '0;
		case (op)
			OP_OFFER: begin
				if (held_count < cap) begin
					if (tag_held(tag, pos)) res.status = ST_DUP;
					else insert_entry(key, tag, kind);
				end else if (held_count == 0 || !(held_key[0] < key)) begin
					res.status = ST_BELOW;
				end else if (tag_held(tag, pos)) begin
					res.status = ST_DUP;
				end else begin
					res.ev_valid = 1'b1;
					res.ev_key   = held_key[0];
					res.ev_tag   = held_tag[0];
					res.ev_kind  = held_kind[0];
					remove_slot(0);
					insert_entry(key, tag, kind);
				end
			end
			OP_FORCE: begin
				if (tag_held(tag, pos)) res.status = ST_DUP;
				else if (held_count >= cap) res.status = ST_FULL;
				else insert_entry(key, tag, kind);
			end
			OP_REMOVE: begin
				if (!tag_held(tag, pos)) begin
					res.status = ST_NOT_FOUND;
				end else begin
					res.status   = ST_REMOVED;
					res.ev_valid = 1'b1;
					res.ev_key   = held_key[pos];
					res.ev_tag   = held_tag[pos];
					res.ev_kind  = held_kind[pos];
					remove_slot(pos);
				end
			end
			default: begin
				if (held_count == 0) begin
					res.status = ST_FULL;
				end else begin
					res.status   = ST_REMOVED;
					res.ev_valid = 1'b1;
					res.ev_key   = held_key[0];
					res.ev_tag   = held_tag[0];
					res.ev_kind  = held_kind[0];
					remove_slot(0);
				end
			end
		endcase
		res.count   = CNT_OUT_W'(held_count);
		res.min_key = (held_count > 0) ? held_key[0] : '0;
		res.min_tag = (held_count > 0) ? held_tag[0] : '0;
		return res;
	endfunction

	function automatic void compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endfunction

	// Drive one request, idling between bursts, and hold it until accepted
	task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
			input logic [TAG_W-1:0] tag, input logic [KIND_W-1:0] kind);
		int gap;
		if (tx_burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			tx_burst_left = $urandom_range(1, 20);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		tx_burst_left--;
		in_valid   <= 1'b1;
		opcode     <= op;
		entry_key  <= key;
		entry_tag  <= tag;
		entry_kind <= kind;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_results = {pending_results, predict_heap_op(op, key, tag, kind)};
	endtask

	// Hold off new requests until every response is back
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [CFG_W-1:0] value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en    <= 1'b0;
		capacity_reg  = value;
	endtask

	// Pop and remove on an empty heap
	task automatic test_empty_heap();
		set_capacity(7'd64);
		send_request(OP_POP, '0, '0, '0);
		send_request(OP_REMOVE, '0, '0, '0);
		wait_for_drain();
	endtask

	// Field extremes, duplicate tags, equal keys, removal from the middle
	task automatic test_insert_and_duplicates();
		send_request(OP_OFFER, '1, '1, 8'hFF);
		send_request(OP_OFFER, '0, '0, 8'h00);
		send_request(OP_OFFER, 64'd5, '0, 8'h11);
		send_request(OP_FORCE, 64'd5, '0, 8'h12);
		send_request(OP_OFFER, 64'd5, 32'd7, 8'h21);
		send_request(OP_FORCE, 64'd5, 32'd8, 8'h22);
		send_request(OP_OFFER, 64'd5, 32'd9, 8'h23);
		send_request(OP_REMOVE, '0, 32'd7, '0);
		send_request(OP_POP, '0, '0, '0);
		wait_for_drain();
	endtask

	// Capacity lowered below the count: heap counts as full
	task automatic test_full_reservoir();
		set_capacity(7'd2);
		send_request(OP_OFFER, 64'd3, 32'd100, 8'h31);
		send_request(OP_OFFER, 64'd5, 32'd8, 8'h32);
		send_request(OP_OFFER, 64'd6, 32'd8, 8'h33);
		send_request(OP_OFFER, 64'd6, 32'd200, 8'h34);
		send_request(OP_FORCE, 64'd7, 32'd300, 8'h35);
		wait_for_drain();
	endtask

	// Zero acts as one, oversize acts as full depth
	task automatic test_capacity_clamp();
		set_capacity(7'd0);
		repeat (4) send_request(OP_POP, '0, '0, '0);
		send_request(OP_OFFER, 64'd9, 32'd1, 8'h41);
		send_request(OP_OFFER, 64'd9, 32'd2, 8'h42);
		send_request(OP_OFFER, 64'd10, 32'd1, 8'h43);
		wait_for_drain();
		set_capacity(7'd127);
		send_request(OP_FORCE, 64'd1, 32'd2, 8'h44);
		send_request(OP_REMOVE, '0, 32'd1, '0);
		wait_for_drain();
	endtask

	// Random requests over a tag pool so duplicates and removals hit
	task automatic run_random_phase(input logic [CFG_W-1:0] cap, input int items);
		int i;
		int pick;
		logic [OP_W-1:0]   op;
		logic [KEY_W-1:0]  key;
		logic [TAG_W-1:0]  tag;
		set_capacity(cap);
		for (i = 0; i < POOL_SIZE; i++) tag_pool[i] = $urandom;
		for (i = 0; i < items; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) op = OP_OFFER;
			else if (pick < 70) op = OP_FORCE;
			else if (pick < 85) op = OP_REMOVE;
			else op = OP_POP;
			pick = $urandom_range(0, 9);
			if (pick == 0) key = $urandom_range(0, 1) ? '0 : '1;
			else if (pick < 4) key = KEY_W'($urandom_range(0, 15));
			else key = {$urandom, $urandom};
			tag = ($urandom_range(0, 3) == 0) ? TAG_W'($urandom)
					: tag_pool[$urandom_range(0, POOL_SIZE - 1)];
			send_request(op, key, tag, KIND_W'($urandom_range(0, 255)));
			if ($urandom_range(0, 49) == 0) wait_for_drain();
		end
		wait_for_drain();
	endtask

	task automatic test_random_traffic();
		run_random_phase(7'd64, 250);
		run_random_phase(7'd1, 60);
		run_random_phase(7'd5, 100);
		run_random_phase(7'd127, 150);
		run_random_phase(7'd0, 40);
		run_random_phase(7'd33, 150);
		run_random_phase(7'd64, 60);
	endtask

	// Receiver ready pattern: always ready, random, or periodic one-cycle ready pulses
	always @(posedge clk) begin
		rx_tick <= rx_tick + 1;
		if (rx_tick % 64 == 0) rx_mode <= $urandom_range(0, 2);
		case (rx_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			default: out_ready <= (rx_tick % 5 == 0);
		endcase
	end

	// Check each response against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("response with no request outstanding");
				mismatches++;
			end else begin
				rx_want = pending_results[0];
				pending_results.delete(0);
				compare_field("status", 64'(rx_want.status), 64'(status));
				compare_field("evicted_valid", 64'(rx_want.ev_valid), 64'(evicted_valid));
				compare_field("evicted_key", rx_want.ev_key, evicted_key);
				compare_field("evicted_tag", 64'(rx_want.ev_tag), 64'(evicted_tag));
				compare_field("evicted_kind", 64'(rx_want.ev_kind), 64'(evicted_kind));
				compare_field("entry_count", 64'(rx_want.count), 64'(entry_count));
				compare_field("min_key", rx_want.min_key, min_key);
				compare_field("min_tag", 64'(rx_want.min_tag), 64'(min_tag));
			end
		end
	end

	// Stop the run if nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		held_count   = 0;
		capacity_reg = CFG_RESET;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_heap();
		test_insert_and_duplicates();
		test_full_reservoir();
		test_capacity_clamp();
		test_random_traffic();
		wait_for_drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
`default_nettype wire
